### rtl/wctd_pkg.sv
package wctd_pkg;

    // Default list capacity, the phenomenon code width and the summary queue depth.
    localparam int MaxPhenomenaDefault = 8;
    localparam int PhenW               = 5;
    localparam int QueueDepth          = 2;

    // Parser phases.
    localparam logic [1:0] PhaseFirst = 2'd0;
    localparam logic [1:0] PhaseCode  = 2'd1;
    localparam logic [1:0] PhaseHeld  = 2'd2;
    localparam logic [1:0] PhasePair  = 2'd3;

    // Intensity codes.
    localparam logic [1:0] IntensityNormal = 2'd0;
    localparam logic [1:0] IntensityLight  = 2'd1;
    localparam logic [1:0] IntensityHeavy  = 2'd2;

    // Intensity prefix characters.
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharPlus  = 8'h2B;

    // Per-token summary handed from the parser to the result sequencer.
    typedef struct packed {
        logic       token_valid;
        logic [1:0] intensity;
        logic [7:0] descriptor_flags;
        logic       temporary_flag;
        logic       list_overflow;
        logic       bank;
    } tok_info_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Descriptor pairs map to a single flag bit; anything else gives zero.
    function automatic logic [7:0] descriptor_bit(input logic [15:0] key);
        logic [7:0] d;
        unique case (key)
            "VC":    d = 8'h01;
            "BL":    d = 8'h02;
            "DR":    d = 8'h04;
            "FZ":    d = 8'h08;
            "PR":    d = 8'h10;
            "MI":    d = 8'h20;
            "BC":    d = 8'h40;
            "TS":    d = 8'h80;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

    // Weather pairs map to a phenomenon code; zero means not a weather pair.
    function automatic logic [PhenW-1:0] weather_code(input logic [15:0] key);
        logic [PhenW-1:0] w;
        unique case (key)
            "SH":    w = 5'd1;
            "BR":    w = 5'd2;
            "DS":    w = 5'd3;
            "DU":    w = 5'd4;
            "DZ":    w = 5'd5;
            "FC":    w = 5'd6;
            "FG":    w = 5'd7;
            "FU":    w = 5'd8;
            "GR":    w = 5'd9;
            "GS":    w = 5'd10;
            "HZ":    w = 5'd11;
            "IC":    w = 5'd12;
            "PE":    w = 5'd13;
            "PL":    w = 5'd13;
            "PO":    w = 5'd14;
            "PY":    w = 5'd15;
            "RA":    w = 5'd16;
            "SA":    w = 5'd17;
            "SG":    w = 5'd18;
            "SN":    w = 5'd19;
            "SQ":    w = 5'd20;
            "SS":    w = 5'd21;
            "UP":    w = 5'd22;
            "VA":    w = 5'd23;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

endpackage

### rtl/wctd_char_if.sv
interface wctd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_token;
    logic       temporary;

    modport source (output valid, output char_code, output end_of_token,
                    output temporary, input ready);
    modport sink (input valid, input char_code, input end_of_token,
                  input temporary, output ready);
endinterface

### rtl/wctd_result_if.sv
interface wctd_result_if;
    logic       valid;
    logic       ready;
    logic       token_valid;
    logic [1:0] intensity;
    logic [4:0] phenomenon;
    logic [7:0] descriptor_flags;
    logic       temporary_flag;
    logic       list_overflow;
    logic       last_result;

    modport source (output valid, output token_valid, output intensity,
                    output phenomenon, output descriptor_flags,
                    output temporary_flag, output list_overflow,
                    output last_result, input ready);
    modport sink (input valid, input token_valid, input intensity,
                  input phenomenon, input descriptor_flags,
                  input temporary_flag, input list_overflow,
                  input last_result, output ready);
endinterface

### rtl/wctd_ram.sv
module wctd_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/wctd_front.sv
module wctd_front
    import wctd_pkg::*;
#(
    parameter int MAX_PHENOMENA = MaxPhenomenaDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    wctd_char_if.sink             chars,
    input  logic                  queue_full,
    output logic                  push,
    output tok_info_t             push_info,
    output logic [$clog2(MAX_PHENOMENA+1)-1:0] push_count,
    output logic                  ram_we,
    output logic [((MAX_PHENOMENA > 1) ? $clog2(MAX_PHENOMENA) : 1):0] ram_waddr,
    output logic [PhenW-1:0]      ram_wdata
);

    localparam int CNT_W = $clog2(MAX_PHENOMENA + 1);
    localparam int IDX_W = (MAX_PHENOMENA > 1) ? $clog2(MAX_PHENOMENA) : 1;

    logic [1:0]       phase_reg, phase_upd, phase_next;
    logic [7:0]       held_reg, held_upd, held_next;
    logic [1:0]       intensity_reg, intensity_upd, intensity_next;
    logic [7:0]       desc_reg, desc_upd, desc_next;
    logic [CNT_W-1:0] count_reg, count_upd, count_next;
    logic             err_reg, err_upd, err_next;
    logic             ovf_reg, ovf_upd, ovf_next;
    logic             bank_reg, bank_next;

    logic             accept;
    logic             letter;
    logic [7:0]       desc_bit;
    logic [PhenW-1:0] wcode;
    logic             tok_ok;

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && !queue_full;
    assign letter      = is_letter(chars.char_code);
    assign desc_bit    = descriptor_bit({1'b0, held_reg[6:0], chars.char_code});
    assign wcode       = weather_code({1'b0, held_reg[6:0], chars.char_code});

    always_comb
    begin
        phase_upd     = phase_reg;
        held_upd      = held_reg;
        intensity_upd = intensity_reg;
        desc_upd      = desc_reg;
        count_upd     = count_reg;
        err_upd       = err_reg;
        ovf_upd       = ovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = {bank_reg, count_reg[IDX_W-1:0]};
        ram_wdata     = wcode;

        if (accept && !err_reg)
        begin
            unique case (phase_reg)
                PhaseFirst:
                begin
                    if (letter)
                    begin
                        held_upd  = chars.char_code | 8'h80;
                        phase_upd = PhaseHeld;
                    end
                    else if (chars.char_code == CharMinus)
                    begin
                        intensity_upd = IntensityLight;
                        phase_upd     = PhaseCode;
                    end
                    else if (chars.char_code == CharPlus)
                    begin
                        intensity_upd = IntensityHeavy;
                        phase_upd     = PhaseCode;
                    end
                    else
                    begin
                        err_upd = 1'b1;
                    end
                end
                PhaseCode:
                begin
                    if (letter)
                    begin
                        held_upd  = chars.char_code | 8'h80;
                        phase_upd = PhaseHeld;
                    end
                    else
                    begin
                        err_upd = 1'b1;
                    end
                end
                PhaseHeld:
                begin
                    if (held_reg[7] && !letter)
                    begin
                        err_upd = 1'b1;
                    end
                    else
                    begin
                        // Descriptor takes precedence; then a weather code joins the list.
                        if (desc_bit != 8'h00)
                        begin
                            desc_upd = desc_reg | desc_bit;
                        end
                        else if (wcode != '0)
                        begin
                            if (count_reg < CNT_W'(MAX_PHENOMENA))
                            begin
                                ram_we    = 1'b1;
                                count_upd = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_upd = 1'b1;
                            end
                        end
                        held_upd  = 8'h00;
                        phase_upd = PhasePair;
                    end
                end
                PhasePair:
                begin
                    held_upd  = chars.char_code[7] ? 8'h00 : chars.char_code;
                    phase_upd = PhaseHeld;
                end
                default:
                begin
                    phase_upd = PhaseFirst;
                end
            endcase
        end

        tok_ok = !err_upd
                 && ((phase_upd == PhasePair) || ((phase_upd == PhaseHeld) && !held_upd[7]))
                 && ((count_upd != '0) || (desc_upd != 8'h00));

        push                       = accept && chars.end_of_token;
        push_info.token_valid      = tok_ok;
        push_info.intensity        = tok_ok ? intensity_upd : IntensityNormal;
        push_info.descriptor_flags = tok_ok ? desc_upd : 8'h00;
        push_info.temporary_flag   = tok_ok && chars.temporary;
        push_info.list_overflow    = tok_ok && ovf_upd;
        push_info.bank             = bank_reg;
        push_count                 = tok_ok ? count_upd : '0;

        if (push)
        begin
            phase_next     = PhaseFirst;
            held_next      = 8'h00;
            intensity_next = IntensityNormal;
            desc_next      = 8'h00;
            count_next     = '0;
            err_next       = 1'b0;
            ovf_next       = 1'b0;
            bank_next      = !bank_reg;
        end
        else
        begin
            phase_next     = phase_upd;
            held_next      = held_upd;
            intensity_next = intensity_upd;
            desc_next      = desc_upd;
            count_next     = count_upd;
            err_next       = err_upd;
            ovf_next       = ovf_upd;
            bank_next      = bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PhaseFirst;
            held_reg      <= 8'h00;
            intensity_reg <= IntensityNormal;
            desc_reg      <= 8'h00;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            intensity_reg <= intensity_next;
            desc_reg      <= desc_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            ovf_reg       <= ovf_next;
            bank_reg      <= bank_next;
        end
    end

endmodule

### rtl/wctd_queue.sv
module wctd_queue
    import wctd_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    input  logic             pop
);

    logic [WIDTH-1:0] entry_reg [QueueDepth];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full       = (count_reg == 2'(QueueDepth));
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/wctd_back.sv
module wctd_back
    import wctd_pkg::*;
#(
    parameter int MAX_PHENOMENA = MaxPhenomenaDefault
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  tok_info_t             head_info,
    input  logic [$clog2(MAX_PHENOMENA+1)-1:0] head_count,
    output logic                  pop,
    output logic                  ram_re,
    output logic [((MAX_PHENOMENA > 1) ? $clog2(MAX_PHENOMENA) : 1):0] ram_raddr,
    input  logic [PhenW-1:0]      ram_rdata,
    wctd_result_if.source         results
);

    localparam int CNT_W = $clog2(MAX_PHENOMENA + 1);
    localparam int IDX_W = (MAX_PHENOMENA > 1) ? $clog2(MAX_PHENOMENA) : 1;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg, s1_valid_next;
    tok_info_t        s1_info_reg;
    logic             s1_last_reg;
    logic             s1_use_list_reg;
    logic             out_valid_reg, out_valid_next;
    tok_info_t        out_info_reg;
    logic [PhenW-1:0] out_phen_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] n_results;
    logic             is_last;
    logic             out_load;
    logic             issue;

    // A token with an empty list still gives one result.
    assign n_results = (head_count == '0) ? CNT_W'(1) : head_count;
    assign is_last   = ((idx_reg + CNT_W'(1)) == n_results);
    assign out_load  = s1_valid_reg && (!out_valid_reg || results.ready);
    assign issue     = head_valid && (!s1_valid_reg || out_load);
    assign pop       = issue && is_last;
    assign ram_re    = issue;
    assign ram_raddr = {head_info.bank, idx_reg[IDX_W-1:0]};

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = is_last ? '0 : (idx_reg + CNT_W'(1));
        end

        s1_valid_next = s1_valid_reg;
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_info_reg     <= head_info;
            s1_last_reg     <= is_last;
            s1_use_list_reg <= (head_count != '0);
        end
        if (out_load)
        begin
            out_info_reg <= s1_info_reg;
            out_phen_reg <= s1_use_list_reg ? ram_rdata : '0;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.token_valid      = out_info_reg.token_valid;
    assign results.intensity        = out_info_reg.intensity;
    assign results.phenomenon       = out_phen_reg;
    assign results.descriptor_flags = out_info_reg.descriptor_flags;
    assign results.temporary_flag   = out_info_reg.temporary_flag;
    assign results.list_overflow    = out_info_reg.list_overflow;
    assign results.last_result      = out_last_reg;

endmodule

### rtl/weather_code_token_decoder.sv
// Throughput: one character item per cycle while the queue is not full; a token's
// results leave at one per cycle while results.ready is high.
// Input stalls only while two finished tokens wait in the two-entry summary queue.
// Reset (rst_n, asynchronous, active low) clears all control state; the list memory
// is not cleared, as only entries written for the token being sequenced are ever used.
module weather_code_token_decoder
    import wctd_pkg::*;
#(
    parameter int MAX_PHENOMENA = MaxPhenomenaDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    wctd_char_if.sink     chars,
    wctd_result_if.source results
);

    // The parser (front) reads one character per cycle unless the queue is full, and
    // keeps the state of the token being parsed. Weather codes are written straight into
    // one half of a two-bank list memory; at the end of a token a summary (flags, count,
    // bank) is pushed into a two-entry queue and the parser moves to the other bank.
    // The sequencer (back) walks the head summary, reading one list entry per cycle
    // unless results stall, via the memory's registered port into an output register.
    // The head entry, and with it its bank, is released once its last read is issued.
    localparam int CNT_W   = $clog2(MAX_PHENOMENA + 1);
    localparam int IDX_W   = (MAX_PHENOMENA > 1) ? $clog2(MAX_PHENOMENA) : 1;
    localparam int RAM_D   = 2 << IDX_W;
    localparam int Q_WIDTH = $bits(tok_info_t) + CNT_W;

    logic               push;
    tok_info_t          push_info;
    logic [CNT_W-1:0]   push_count;
    logic               queue_full;
    logic               head_valid;
    logic [Q_WIDTH-1:0] head_data;
    tok_info_t          head_info;
    logic [CNT_W-1:0]   head_count;
    logic               pop;

    logic               ram_we;
    logic [IDX_W:0]     ram_waddr;
    logic [PhenW-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W:0]     ram_raddr;
    logic [PhenW-1:0]   ram_rdata;

    wctd_front #(
        .MAX_PHENOMENA (MAX_PHENOMENA)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .push_info  (push_info),
        .push_count (push_count),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    wctd_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_info, push_count}),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    assign head_info  = head_data[Q_WIDTH-1:CNT_W];
    assign head_count = head_data[CNT_W-1:0];

    wctd_ram #(
        .WIDTH (PhenW),
        .DEPTH (RAM_D)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    wctd_back #(
        .MAX_PHENOMENA (MAX_PHENOMENA)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_info  (head_info),
        .head_count (head_count),
        .pop        (pop),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .results    (results)
    );

endmodule

### rtl/wctd_checker.sv
module wctd_checker
    import wctd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       token_valid,
    input logic [1:0] intensity,
    input logic [4:0] phenomenon,
    input logic [7:0] descriptor_flags,
    input logic       temporary_flag,
    input logic       list_overflow,
    input logic       last_result
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({token_valid, intensity, phenomenon, descriptor_flags,
                        temporary_flag, list_overflow, last_result}))
        else $error("result payload changed while stalled");

    // An invalid token gives a single, otherwise empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !token_valid |-> last_result && (intensity == IntensityNormal)
            && (phenomenon == '0) && (descriptor_flags == 8'h00)
            && !temporary_flag && !list_overflow)
        else $error("invalid token result is not a lone empty result");

    // A valid token with no listed code gives exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_valid && (phenomenon == '0) |-> last_result)
        else $error("empty-list token gave more than one result");

    // A valid token recognised something.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_valid |-> (phenomenon != '0) || (descriptor_flags != 8'h00))
        else $error("valid token with nothing recognised");

    // Intensity never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (intensity == IntensityNormal) || (intensity == IntensityLight)
            || (intensity == IntensityHeavy))
        else $error("intensity out of range");

endmodule

bind weather_code_token_decoder wctd_checker u_wctd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (results.valid),
    .out_ready        (results.ready),
    .token_valid      (results.token_valid),
    .intensity        (results.intensity),
    .phenomenon       (results.phenomenon),
    .descriptor_flags (results.descriptor_flags),
    .temporary_flag   (results.temporary_flag),
    .list_overflow    (results.list_overflow),
    .last_result      (results.last_result)
);
